@@ src/mwo_pkg.sv @@
package mwo_pkg;

	// default sizes
	localparam int PHASE_BITS_DEF      = 32;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int SAMPLE_BITS_DEF     = 16;

	// fixed field widths
	localparam int ENV_W       = 17;
	localparam int LEVEL_W     = 16;
	localparam int STEP_W      = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int IN_TDATA_W  = 24;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_SELECT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_LEVEL  = 2'd2;

	// sine polynomial coefficients, Q30
	localparam longint COEF1 = 64'sd1686629713;
	localparam longint COEF3 = -64'sd693598669;
	localparam longint COEF5 = 64'sd85569306;
	localparam longint COEF7 = -64'sd5026996;
	localparam longint COEF9 = 64'sd172272;

	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_SAW      = 2'd1,
		WAVE_SQUARE   = 2'd2,
		WAVE_TRIANGLE = 2'd3
	} wave_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_ROUND
	} state_t;

	// quarter-wave entry k, evaluated at elaboration
	function automatic longint sine_entry(int k, int tbits, int sbits);
		longint x;
		longint x2;
		longint acc;
		longint s;
		longint h;
		longint e;
		x   = longint'(k) <<< (30 - tbits);
		x2  = (x * x) >>> 30;
		acc = COEF9;
		acc = COEF7 + ((acc * x2) >>> 30);
		acc = COEF5 + ((acc * x2) >>> 30);
		acc = COEF3 + ((acc * x2) >>> 30);
		acc = COEF1 + ((acc * x2) >>> 30);
		s   = (acc * x) >>> 30;
		h   = longint'(1) <<< (sbits - 1);
		e   = (s * h + (longint'(1) <<< 29)) >>> 30;
		if (e > h - 1) begin
			e = h - 1;
		end
		if (e < 0) begin
			e = 0;
		end
		return e;
	endfunction

endpackage

@@ src/multi_waveform_oscillator_top.sv @@
// A sample reaches m_axis through states ST_MUL1, ST_MUL2 and ST_ROUND and the
// output register. The single shared multiplier runs twice per sample (wave x
// level, then x envelope), then round/saturate; beats enter only in ST_IDLE.
// The round cycle holds while an earlier sample is still unread on m_axis.
// A finished sample waits in the output register while the next beat is taken.
// Reset (arst_n low, asynchronous): phase, config registers and m_axis_tvalid clear to zero.
module multi_waveform_oscillator_top #(
	parameter int PHASE_BITS      = mwo_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = mwo_pkg::SINE_TABLE_BITS_DEF,
	parameter int SAMPLE_BITS     = mwo_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// config write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mwo_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mwo_pkg::CFG_DATA_W-1:0]        cfg_data,
	// input beats
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [mwo_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // [16:0] envelope_gain
	// output beats
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata   // [SB-1:0] sample_out
);

	localparam int PB    = PHASE_BITS;
	localparam int TB    = SINE_TABLE_BITS;
	localparam int SB    = SAMPLE_BITS;
	localparam int TN    = 1 << TB;
	localparam int KMAX  = (2 + TB > SB + 1) ? 2 + TB : SB + 1;
	localparam int AW    = SB + mwo_pkg::LEVEL_W;
	localparam int PW    = AW + mwo_pkg::ENV_W;
	localparam int OUT_W = ((SB + 7) / 8) * 8;

	localparam logic signed [SB-1:0] W_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] W_MIN = {1'b1, {(SB-1){1'b0}}};

	mwo_pkg::state_t state_q, state_d;

	mwo_pkg::wave_t               wave_sel_q;
	logic [mwo_pkg::STEP_W-1:0]   phase_step_q;
	logic [mwo_pkg::LEVEL_W-1:0]  note_level_q;
	logic [PB-1:0]                phase_q;

	logic [mwo_pkg::ENV_W-1:0]    env_q;
	logic [SB-2:0]                rom_q;
	logic                         neg_q;
	logic signed [SB-1:0]         wave_q;
	logic signed [PW-1:0]         prod_q;
	logic [SB-1:0]                out_q;
	logic                         out_valid_q;

	logic in_fire;
	logic out_load;
	logic mul_en;

	// config writes, always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_sel_q   <= mwo_pkg::WAVE_SINE;
			phase_step_q <= '0;
			note_level_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mwo_pkg::REG_WAVE_SELECT: wave_sel_q   <= mwo_pkg::wave_t'(cfg_data[1:0]);
				mwo_pkg::REG_PHASE_STEP:  phase_step_q <= cfg_data;
				mwo_pkg::REG_NOTE_LEVEL:  note_level_q <= cfg_data[mwo_pkg::LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// quarter-wave sine table, constant
	logic [SB-2:0] sine_rom [0:TN];

	for (genvar k = 0; k <= TN; k++) begin : g_rom
		assign sine_rom[k] = (SB-1)'(mwo_pkg::sine_entry(k, TB, SB));
	end

	// top bits of the phase, zero filled when the phase is short
	logic [PB+KMAX-1:0] phase_wide;
	logic [TB+1:0]      sin_top;
	logic [TB:0]        sin_pos;
	logic [SB:0]        tri_v;
	logic signed [SB+1:0] tri_d;
	logic signed [SB-1:0] wave_other;

	assign phase_wide = {phase_q, KMAX'(0)};
	assign sin_top    = phase_wide[PB+KMAX-1 -: (TB+2)];
	assign tri_v      = phase_wide[PB+KMAX-1 -: (SB+1)];
	assign sin_pos    = sin_top[TB] ? ((TB+1)'(TN) - {1'b0, sin_top[TB-1:0]})
	                                : {1'b0, sin_top[TB-1:0]};
	assign tri_d      = $signed((SB+2)'(3 << (SB-1))) - $signed({1'b0, tri_v});

	// saw, square and triangle from the current phase
	always_comb begin
		case (wave_sel_q)
			mwo_pkg::WAVE_SAW: begin
				wave_other = {~tri_v[SB], tri_v[SB-1:1]};
			end
			mwo_pkg::WAVE_SQUARE: begin
				wave_other = tri_v[SB] ? W_MIN : W_MAX;
			end
			mwo_pkg::WAVE_TRIANGLE: begin
				if (!tri_v[SB]) begin
					wave_other = {~tri_v[SB-1], tri_v[SB-2:0]};
				end else if (tri_d > $signed({{2{1'b0}}, W_MAX})) begin
					wave_other = W_MAX;
				end else begin
					wave_other = SB'(tri_d);
				end
			end
			default: begin
				wave_other = '0;
			end
		endcase
	end

	// shared multiplier: wave x level, then x envelope
	logic signed [SB-1:0]                w_cur;
	logic signed [AW-1:0]                mul_a;
	logic [mwo_pkg::ENV_W-1:0]           mul_b;
	logic signed [PW:0]                  mul_p;

	assign w_cur = (wave_sel_q == mwo_pkg::WAVE_SINE)
	             ? (neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q}))
	             : wave_q;
	assign mul_a = (state_q == mwo_pkg::ST_MUL1) ? AW'(w_cur) : AW'(prod_q);
	assign mul_b = (state_q == mwo_pkg::ST_MUL1) ? {1'b0, note_level_q} : env_q;
	assign mul_p = mul_a * $signed({1'b0, mul_b});

	// round and saturate
	logic signed [PW-1:0] rnd_sum;
	logic signed [SB:0]   rnd_q;
	logic [SB-1:0]        sat_val;

	assign rnd_sum = prod_q + $signed(PW'(64'h8000_0000));
	assign rnd_q   = rnd_sum[PW-1:32];
	always_comb begin
		if (rnd_q > $signed({1'b0, W_MAX})) begin
			sat_val = W_MAX;
		end else if (rnd_q < $signed({1'b1, W_MIN})) begin
			sat_val = W_MIN;
		end else begin
			sat_val = rnd_q[SB-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mwo_pkg::ST_IDLE:  if (s_axis_tvalid) state_d = mwo_pkg::ST_MUL1;
			mwo_pkg::ST_MUL1:  state_d = mwo_pkg::ST_MUL2;
			mwo_pkg::ST_MUL2:  state_d = mwo_pkg::ST_ROUND;
			mwo_pkg::ST_ROUND: if (!out_valid_q || m_axis_tready) state_d = mwo_pkg::ST_IDLE;
			default:           state_d = mwo_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		mul_en        = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			mwo_pkg::ST_IDLE:  s_axis_tready = 1'b1;
			mwo_pkg::ST_MUL1:  mul_en = 1'b1;
			mwo_pkg::ST_MUL2:  mul_en = 1'b1;
			mwo_pkg::ST_ROUND: out_load = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mwo_pkg::ST_IDLE;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				phase_q <= phase_q + PB'(phase_step_q);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			env_q  <= s_axis_tdata[mwo_pkg::ENV_W-1:0];
			rom_q  <= sine_rom[sin_pos];
			neg_q  <= sin_top[TB+1];
			wave_q <= wave_other;
		end
		if (mul_en) begin
			prod_q <= mul_p[PW-1:0];
		end
		if (out_load) begin
			out_q <= sat_val;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_q);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_axis_tready)
		else $error("input taken while busy");

	a_phase_advance: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> phase_q == $past(phase_q + PB'(phase_step_q)))
		else $error("phase did not advance by the step");

	a_result_posted: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_axis_tvalid && state_q == mwo_pkg::ST_IDLE)
		else $error("finished sample not posted");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || m_axis_tready)
		else $error("pending sample overwritten");
`endif

endmodule
